### src/bcs_pkg.sv
// ----------------------------------------------------------------------------
// bcs_pkg
// shared types and constants of the banned call scanner
// ----------------------------------------------------------------------------
package bcs_pkg;

  localparam int NAME_IDX_W = 4;
  localparam int NAME_LEN_W = 5;
  localparam int CNT_W      = 32;
  localparam int CFG_W      = 64;
  localparam int CFG_IDX_W  = 2;

  localparam logic [7:0] CH_SLASH     = 8'h2f;
  localparam logic [7:0] CH_STAR      = 8'h2a;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5c;
  localparam logic [7:0] CH_NEWLINE   = 8'h0a;
  localparam logic [7:0] CH_LPAREN    = 8'h28;

  localparam logic [CFG_IDX_W-1:0] REG_NAME_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NAME_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NAME_LEN  = 2'd2;

  typedef struct packed {
    logic in_range;
    logic opener_done;
  } lex_info_t;

endpackage

### src/bcs_lexer.sv
// ----------------------------------------------------------------------------
// bcs_lexer
// tracks code, string, line comment and block comment modes per byte
// ----------------------------------------------------------------------------
module bcs_lexer import bcs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] text_byte,
  input  logic       end_of_file,
  output lex_info_t  info
);

  typedef enum logic [1:0] {
    MODE_CODE, MODE_STRING, MODE_LINE, MODE_BLOCK
  } mode_t;

  typedef enum logic [1:0] {
    PEND_NONE, PEND_SLASH, PEND_STAR, PEND_BACKSLASH
  } pend_t;

  mode_t mode, mode_next;
  pend_t pend, pend_next;

  always_comb begin
    mode_next        = mode;
    pend_next        = PEND_NONE;
    info.in_range    = 1'b1;
    info.opener_done = 1'b0;
    unique case (mode)
      MODE_CODE: begin
        info.in_range = 1'b0;
        if (pend == PEND_SLASH && (text_byte == CH_SLASH || text_byte == CH_STAR)) begin
          info.in_range    = 1'b1;
          info.opener_done = 1'b1;
          mode_next        = (text_byte == CH_SLASH) ? MODE_LINE : MODE_BLOCK;
        end else if (text_byte == CH_QUOTE) begin
          info.in_range = 1'b1;
          mode_next     = MODE_STRING;
        end else if (text_byte == CH_SLASH) begin
          pend_next = PEND_SLASH;
        end
      end
      MODE_STRING: begin
        if (pend == PEND_BACKSLASH) begin
          pend_next = PEND_NONE;
        end else if (text_byte == CH_BACKSLASH) begin
          pend_next = PEND_BACKSLASH;
        end else if (text_byte == CH_QUOTE) begin
          mode_next = MODE_CODE;
        end
      end
      MODE_LINE: begin
        if (text_byte == CH_NEWLINE) begin
          info.in_range = 1'b0;
          mode_next     = MODE_CODE;
        end
      end
      MODE_BLOCK: begin
        if (pend == PEND_STAR && text_byte == CH_SLASH) begin
          mode_next = MODE_CODE;
        end else if (text_byte == CH_STAR) begin
          pend_next = PEND_STAR;
        end
      end
      default: begin
        mode_next = MODE_CODE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_CODE;
      pend <= PEND_NONE;
    end else if (step) begin
      if (end_of_file) begin
        mode <= MODE_CODE;
        pend <= PEND_NONE;
      end else begin
        mode <= mode_next;
        pend <= pend_next;
      end
    end
  end

endmodule

### src/bcs_matcher.sv
// ----------------------------------------------------------------------------
// bcs_matcher
// name matching, call detection and offset and line counting per byte
// ----------------------------------------------------------------------------
module bcs_matcher import bcs_pkg::*; #(
  parameter int MAX_NAME_BYTES = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  logic [7:0]            text_byte,
  input  logic                  end_of_file,
  input  lex_info_t             info,
  input  logic [2*CFG_W-1:0]    name_bytes,
  input  logic [NAME_LEN_W-1:0] name_length,
  output logic                  hit,
  output logic [CNT_W-1:0]      hit_offset,
  output logic [CNT_W-1:0]      hit_line
);

  localparam int PROG_W = $clog2(MAX_NAME_BYTES + 1);
  localparam logic [NAME_LEN_W-1:0] MAX_LEN = NAME_LEN_W'(MAX_NAME_BYTES);

  function automatic logic is_word(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) ||
           (c >= 8'h30 && c <= 8'h39) || c == 8'h5f;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0a || c == 8'h0b ||
           c == 8'h0c || c == 8'h0d;
  endfunction

  logic [PROG_W-1:0] prog, prog_next;
  logic              after_name, after_name_next;
  logic              prev_word;
  logic              supp, supp_next;
  logic [CNT_W-1:0]  line_cnt, byte_cnt;
  logic [CNT_W-1:0]  start_offset, start_offset_next;
  logic [CNT_W-1:0]  start_line, start_line_next;

  logic [PROG_W-1:0]     len;
  logic [NAME_IDX_W-1:0] idx;
  logic [7:0]            cur_name_byte;
  logic [7:0]            first_name_byte;
  logic                  word;
  logic                  restart;

  always_comb begin
    if (name_length == '0) begin
      len = PROG_W'(1);
    end else if (name_length > MAX_LEN) begin
      len = PROG_W'(MAX_NAME_BYTES);
    end else begin
      len = PROG_W'(name_length);
    end
  end

  assign idx             = NAME_IDX_W'(prog);
  assign cur_name_byte   = name_bytes[idx*8 +: 8];
  assign first_name_byte = name_bytes[7:0];
  assign word            = is_word(text_byte);

  always_comb begin
    prog_next         = prog;
    after_name_next   = after_name;
    supp_next         = supp;
    start_offset_next = start_offset;
    start_line_next   = start_line;
    restart           = 1'b1;
    hit               = 1'b0;

    if (info.opener_done && prog == PROG_W'(1)) begin
      supp_next = 1'b1;
    end

    if (prog != '0) begin
      if (!after_name) begin
        if (text_byte == cur_name_byte) begin
          prog_next = prog + PROG_W'(1);
          if (prog_next >= len) begin
            after_name_next = 1'b1;
          end
          restart = 1'b0;
        end
      end else if (text_byte == CH_LPAREN) begin
        hit             = !supp_next;
        prog_next       = '0;
        after_name_next = 1'b0;
        supp_next       = 1'b0;
        restart         = 1'b0;
      end else if (is_space(text_byte)) begin
        restart = 1'b0;
      end
      if (restart) begin
        prog_next       = '0;
        after_name_next = 1'b0;
        supp_next       = 1'b0;
      end
    end

    if (restart && text_byte == first_name_byte && prev_word != word) begin
      prog_next         = PROG_W'(1);
      after_name_next   = (len == PROG_W'(1));
      start_offset_next = byte_cnt;
      start_line_next   = line_cnt;
      supp_next         = info.in_range;
    end
  end

  assign hit_offset = start_offset;
  assign hit_line   = start_line;

  always_ff @(posedge clk) begin
    if (rst) begin
      prog         <= '0;
      after_name   <= 1'b0;
      prev_word    <= 1'b0;
      supp         <= 1'b0;
      line_cnt     <= CNT_W'(1);
      byte_cnt     <= '0;
      start_offset <= '0;
      start_line   <= CNT_W'(1);
    end else if (step) begin
      if (end_of_file) begin
        prog         <= '0;
        after_name   <= 1'b0;
        prev_word    <= 1'b0;
        supp         <= 1'b0;
        line_cnt     <= CNT_W'(1);
        byte_cnt     <= '0;
        start_offset <= '0;
        start_line   <= CNT_W'(1);
      end else begin
        prog         <= prog_next;
        after_name   <= after_name_next;
        prev_word    <= word;
        supp         <= supp_next;
        start_offset <= start_offset_next;
        start_line   <= start_line_next;
        if (text_byte == CH_NEWLINE && line_cnt != '1) begin
          line_cnt <= line_cnt + CNT_W'(1);
        end
        if (byte_cnt != '1) begin
          byte_cnt <= byte_cnt + CNT_W'(1);
        end
      end
    end
  end

endmodule

### src/banned_call_scanner_core.sv
// ----------------------------------------------------------------------------
// banned_call_scanner_core
// finds calls to one configured identifier in a source text byte stream
// ----------------------------------------------------------------------------
//  channel  | handshake          | beat payload
//  text     | text_valid/stall   | text_byte, end_of_file
//  call     | call_valid/stall   | call_offset, call_line
//  config   | cfg_write          | cfg_index, cfg_data
//
//  one byte per cycle while no call beat is stalled; a byte waits in the
//  input register; its call, if any, goes to the result register on advance
//  lexer and matcher state update from the input register as bytes advance
//  rst clears all control state; name registers reset to zero, length one
//  a stalled call beat holds the input register, which then stalls text
// ----------------------------------------------------------------------------
module banned_call_scanner_core import bcs_pkg::*; #(
  parameter int MAX_NAME_BYTES = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 text_valid,
  output logic                 text_stall,
  input  logic [7:0]           text_byte,
  input  logic                 end_of_file,
  output logic                 call_valid,
  input  logic                 call_stall,
  output logic [CNT_W-1:0]     call_offset,
  output logic [CNT_W-1:0]     call_line,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic [CFG_W-1:0]      name_bytes_low;
  logic [CFG_W-1:0]      name_bytes_high;
  logic [NAME_LEN_W-1:0] name_length;

  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_eof;
  logic       advance;
  logic       accept;

  lex_info_t        info;
  logic             hit;
  logic [CNT_W-1:0] hit_offset;
  logic [CNT_W-1:0] hit_line;

  assign advance    = in_valid && (!call_valid || !call_stall);
  assign text_stall = in_valid && !advance;
  assign accept     = text_valid && !text_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      name_bytes_low  <= '0;
      name_bytes_high <= '0;
      name_length     <= NAME_LEN_W'(1);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_NAME_LOW:  name_bytes_low  <= cfg_data;
        REG_NAME_HIGH: name_bytes_high <= cfg_data;
        REG_NAME_LEN:  name_length     <= cfg_data[NAME_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (accept) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
    if (accept) begin
      in_byte <= text_byte;
      in_eof  <= end_of_file;
    end
  end

  bcs_lexer u_lexer (
    .clk         (clk),
    .rst         (rst),
    .step        (advance),
    .text_byte   (in_byte),
    .end_of_file (in_eof),
    .info        (info)
  );

  bcs_matcher #(
    .MAX_NAME_BYTES (MAX_NAME_BYTES)
  ) u_matcher (
    .clk         (clk),
    .rst         (rst),
    .step        (advance),
    .text_byte   (in_byte),
    .end_of_file (in_eof),
    .info        (info),
    .name_bytes  ({name_bytes_high, name_bytes_low}),
    .name_length (name_length),
    .hit         (hit),
    .hit_offset  (hit_offset),
    .hit_line    (hit_line)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      call_valid <= 1'b0;
    end else if (advance) begin
      call_valid <= hit;
    end else if (!call_stall) begin
      call_valid <= 1'b0;
    end
    if (advance && hit) begin
      call_offset <= hit_offset;
      call_line   <= hit_line;
    end
  end

endmodule

### src/bcs_checker.sv
// ----------------------------------------------------------------------------
// bcs_checker
// port level checks of the banned call scanner
// ----------------------------------------------------------------------------
module bcs_checker import bcs_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             text_stall,
  input logic             call_valid,
  input logic             call_stall,
  input logic [CNT_W-1:0] call_offset,
  input logic [CNT_W-1:0] call_line
);

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !call_valid && !text_stall)
    else $error("call beat or text stall right after reset");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    text_stall |-> call_valid && call_stall)
    else $error("text stalled while result register free");

  a_line_nonzero: assert property (@(posedge clk) disable iff (rst)
    call_valid |-> call_line != '0)
    else $error("call beat with line zero");

  a_beat_holds: assert property (@(posedge clk) disable iff (rst)
    call_valid && call_stall |=> call_valid && $stable(call_offset) &&
      $stable(call_line))
    else $error("stalled call beat changed");

endmodule

bind banned_call_scanner_core bcs_checker u_bcs_checker (
  .clk         (clk),
  .rst         (rst),
  .text_stall  (text_stall),
  .call_valid  (call_valid),
  .call_stall  (call_stall),
  .call_offset (call_offset),
  .call_line   (call_line)
);

### dv/banned_call_scanner_core_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// banned_call_scanner_core_checker
// watches the text, call and config ports of the scanner, runs its own
// lexer and matcher on every accepted text beat and compares each call beat
// with the oldest predicted call
// ----------------------------------------------------------------------------
module banned_call_scanner_core_checker import bcs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 text_valid,
  input  logic                 text_stall,
  input  logic [7:0]           text_byte,
  input  logic                 end_of_file,
  input  logic                 call_valid,
  input  logic                 call_stall,
  input  logic [CNT_W-1:0]     call_offset,
  input  logic [CNT_W-1:0]     call_line,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output int                   fail_count,
  output int                   calls_pending
);

  typedef enum logic [1:0] {
    LEX_CODE,
    LEX_STRING,
    LEX_LINE_COMMENT,
    LEX_BLOCK_COMMENT
  } lex_mode_e;

  typedef enum logic [1:0] {
    PEND_NONE,
    PEND_SLASH,
    PEND_STAR,
    PEND_BACKSLASH
  } lookahead_e;

  typedef struct packed {
    logic [CNT_W-1:0] offset;
    logic [CNT_W-1:0] line;
  } call_rec_t;

  localparam int               MAX_NAME_BYTES = 16;
  localparam int               MAX_REPORTS    = 10;
  localparam logic [CNT_W-1:0] CNT_MAX        = '1;
  localparam logic [7:0]       CH_SPACE       = 8'h20;
  localparam logic [7:0]       CH_TAB         = 8'h09;
  localparam logic [7:0]       CH_VTAB        = 8'h0b;
  localparam logic [7:0]       CH_FORMFEED    = 8'h0c;
  localparam logic [7:0]       CH_RETURN      = 8'h0d;
  localparam logic [7:0]       CH_UNDERSCORE  = 8'h5f;

  logic [CFG_W-1:0]      name_lo;
  logic [CFG_W-1:0]      name_hi;
  logic [NAME_LEN_W-1:0] name_len;

  lex_mode_e        lex_mode;
  lookahead_e       lookahead;
  int               progress;
  bit               after_name;
  bit               prev_word;
  bit               start_hidden;
  logic [CNT_W-1:0] line_cnt;
  logic [CNT_W-1:0] byte_cnt;
  logic [CNT_W-1:0] start_off;
  logic [CNT_W-1:0] start_ln;

  call_rec_t expected_calls[$];
  call_rec_t oldest_call;
  int        mismatches;

  function automatic logic [7:0] name_char(int k);
    logic [CFG_W-1:0] w;
    w = (k[3:0] < 8) ? name_lo : name_hi;
    return w[k[2:0]*8 +: 8];
  endfunction

  function automatic bit is_word_char(logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) ||
           (c >= 8'h30 && c <= 8'h39) || c == CH_UNDERSCORE;
  endfunction

  function automatic bit is_blank(logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_NEWLINE || c == CH_VTAB ||
           c == CH_FORMFEED || c == CH_RETURN;
  endfunction

  function automatic void clear_scan();
    lex_mode     = LEX_CODE;
    lookahead    = PEND_NONE;
    progress     = 0;
    after_name   = 1'b0;
    prev_word    = 1'b0;
    start_hidden = 1'b0;
    line_cnt     = 1;
    byte_cnt     = 0;
    start_off    = 0;
    start_ln     = 1;
  endfunction

  function automatic void scan_byte(logic [7:0] c, logic eof);
    int len;
    bit in_range;
    bit opener_done;
    bit word;
    bit restart;
    len = (name_len == 0) ? 1 :
          (int'(name_len) > MAX_NAME_BYTES) ? MAX_NAME_BYTES : int'(name_len);
    in_range    = 1'b0;
    opener_done = 1'b0;
    word        = is_word_char(c);
    restart     = 1'b1;

    case (lex_mode)
      LEX_CODE: begin
        if (lookahead == PEND_SLASH && (c == CH_SLASH || c == CH_STAR)) begin
          in_range    = 1'b1;
          opener_done = 1'b1;
          lex_mode    = (c == CH_SLASH) ? LEX_LINE_COMMENT : LEX_BLOCK_COMMENT;
          lookahead   = PEND_NONE;
        end else if (c == CH_QUOTE) begin
          in_range  = 1'b1;
          lex_mode  = LEX_STRING;
          lookahead = PEND_NONE;
        end else begin
          lookahead = (c == CH_SLASH) ? PEND_SLASH : PEND_NONE;
        end
      end
      LEX_STRING: begin
        in_range = 1'b1;
        if (lookahead == PEND_BACKSLASH) begin
          lookahead = PEND_NONE;
        end else if (c == CH_BACKSLASH) begin
          lookahead = PEND_BACKSLASH;
        end else if (c == CH_QUOTE) begin
          lex_mode  = LEX_CODE;
          lookahead = PEND_NONE;
        end else begin
          lookahead = PEND_NONE;
        end
      end
      LEX_LINE_COMMENT: begin
        in_range = (c != CH_NEWLINE);
        if (c == CH_NEWLINE) lex_mode = LEX_CODE;
        lookahead = PEND_NONE;
      end
      default: begin
        in_range = 1'b1;
        if (lookahead == PEND_STAR && c == CH_SLASH) begin
          lex_mode  = LEX_CODE;
          lookahead = PEND_NONE;
        end else begin
          lookahead = (c == CH_STAR) ? PEND_STAR : PEND_NONE;
        end
      end
    endcase

    // a match begun on a slash that turned out to open a comment
    if (opener_done && progress == 1) start_hidden = 1'b1;

    if (progress != 0) begin
      if (!after_name) begin
        if (c == name_char(progress)) begin
          progress++;
          if (progress >= len) after_name = 1'b1;
          restart = 1'b0;
        end
      end else if (c == CH_LPAREN) begin
        if (!start_hidden)
          expected_calls.insert(expected_calls.size(), call_rec_t'{start_off, start_ln});
        progress     = 0;
        after_name   = 1'b0;
        start_hidden = 1'b0;
        restart      = 1'b0;
      end else if (is_blank(c)) begin
        restart = 1'b0;
      end
      if (restart) begin
        progress     = 0;
        after_name   = 1'b0;
        start_hidden = 1'b0;
      end
    end
    if (restart && progress == 0 && c == name_char(0) && prev_word != word) begin
      progress     = 1;
      after_name   = (len == 1);
      start_off    = byte_cnt;
      start_ln     = line_cnt;
      start_hidden = in_range;
    end

    prev_word = word;
    if (c == CH_NEWLINE && line_cnt != CNT_MAX) line_cnt++;
    if (byte_cnt != CNT_MAX) byte_cnt++;
    if (eof) clear_scan();
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      name_lo  = '0;
      name_hi  = '0;
      name_len = NAME_LEN_W'(1);
      clear_scan();
      expected_calls.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_NAME_LOW:  name_lo = cfg_data;
          REG_NAME_HIGH: name_hi = cfg_data;
          REG_NAME_LEN:  name_len = cfg_data[NAME_LEN_W-1:0];
          default: ;
        endcase
      end
      if (call_valid && !call_stall) begin
        if (expected_calls.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected call beat: offset %0d line %0d", call_offset, call_line);
        end else begin
          oldest_call = expected_calls.pop_front();
          if (call_offset !== oldest_call.offset || call_line !== oldest_call.line) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("call beat mismatch: expected offset %0d line %0d, got offset %0d line %0d",
                       oldest_call.offset, oldest_call.line, call_offset, call_line);
          end
        end
      end
      if (text_valid && !text_stall) scan_byte(text_byte, end_of_file);
    end
    calls_pending <= expected_calls.size();
    fail_count    <= mismatches;
  end

endmodule

### dv/banned_call_scanner_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// banned_call_scanner_core_test
// feeds the scanner short source files built from calls, comments, strings,
// escapes and noise under a series of identifier settings, with random gaps
// on both channels and one long hold on the call side; the checker predicts
// and compares every call beat
// ----------------------------------------------------------------------------
module banned_call_scanner_core_test import bcs_pkg::*;;

  localparam int                   LIMIT_CYCLES     = 200000;
  localparam int                   RANDOM_BYTES     = 1300;
  localparam int                   LONG_HOLD_CYCLES = 200;
  localparam int                   SETTLE_CYCLES    = 10;
  localparam int                   NAME_SLOTS       = 16;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE        = 2'd3;
  localparam logic [7:0]           CH_SPACE         = 8'h20;
  localparam logic [7:0]           CH_TAB           = 8'h09;
  localparam logic [7:0]           CH_VTAB          = 8'h0b;
  localparam logic [7:0]           CH_FORMFEED      = 8'h0c;
  localparam logic [7:0]           CH_RETURN        = 8'h0d;

  logic                 clk;
  logic                 rst;
  logic                 text_valid;
  logic                 text_stall;
  logic [7:0]           text_byte;
  logic                 end_of_file;
  logic                 call_valid;
  logic                 call_stall;
  logic [CNT_W-1:0]     call_offset;
  logic [CNT_W-1:0]     call_line;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 rx_stall;
  logic                 long_hold;
  int                   fail_count;
  int                   calls_pending;

  bit         tx_idle_on;
  bit         rx_idle_on;
  bit         hold_req;
  logic [7:0] name_buf [NAME_SLOTS];
  int         name_n;
  logic [7:0] file_q[$];
  int         random_bytes;
  int         phase;

  assign call_stall = rx_stall | long_hold;

  banned_call_scanner_core uut (.*);

  banned_call_scanner_core_checker chk (.*);

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin : watchdog
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("TB_ERROR");
    $finish;
  end

  function automatic logic [7:0] pick_word_char();
    int r;
    r = $urandom_range(0, 62);
    if (r < 26) return 8'(8'h61 + r);
    if (r < 52) return 8'(8'h41 + r - 26);
    if (r < 62) return 8'(8'h30 + r - 52);
    return 8'h5f;
  endfunction

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(0, 5))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_NEWLINE;
      3: return CH_VTAB;
      4: return CH_FORMFEED;
      default: return CH_RETURN;
    endcase
  endfunction

  function automatic logic [7:0] pick_symbol();
    string syms;
    syms = "+-=<>!&|~^%;,.?:#";
    return syms[$urandom_range(0, syms.len() - 1)];
  endfunction

  function automatic void queue_byte(logic [7:0] b);
    file_q.insert(file_q.size(), b);
  endfunction

  function automatic void push_str(string s);
    for (int i = 0; i < s.len(); i++) queue_byte(s[i]);
  endfunction

  function automatic void push_name(int n);
    for (int i = 0; i < n; i++) queue_byte(name_buf[i]);
  endfunction

  function automatic void add_call();
    case ($urandom_range(0, 4))
      0: ;
      1: queue_byte(pick_word_char());
      2: queue_byte(pick_symbol());
      default: queue_byte(pick_blank());
    endcase
    push_name(name_n);
    repeat ($urandom_range(0, 2)) queue_byte(pick_blank());
    queue_byte(CH_LPAREN);
  endfunction

  // body of a string or comment
  function automatic void add_inner();
    repeat ($urandom_range(1, 3)) begin
      case ($urandom_range(0, 3))
        0: add_call();
        1: begin
          queue_byte(CH_BACKSLASH);
          queue_byte($urandom_range(0, 1) ? CH_QUOTE : pick_word_char());
        end
        2: queue_byte(CH_STAR);
        default: queue_byte(pick_word_char());
      endcase
    end
  endfunction

  function automatic void add_fragment();
    case ($urandom_range(0, 11))
      0, 1, 2, 3: add_call();
      4: begin
        push_name($urandom_range(1, name_n));
        queue_byte(8'($urandom_range(0, 255)));
      end
      5: begin
        queue_byte(CH_QUOTE);
        add_inner();
        queue_byte(CH_QUOTE);
      end
      6: begin
        push_str("//");
        add_inner();
        queue_byte(CH_NEWLINE);
      end
      7: begin
        push_str("/*");
        add_inner();
        push_str("*/");
      end
      8: repeat ($urandom_range(1, 4)) queue_byte(pick_word_char());
      9: repeat ($urandom_range(1, 3)) queue_byte(8'($urandom_range(0, 255)));
      10: repeat ($urandom_range(1, 2)) queue_byte(pick_blank());
      default: begin
        case ($urandom_range(0, 3))
          0: queue_byte(CH_SLASH);
          1: queue_byte(CH_STAR);
          2: queue_byte(CH_BACKSLASH);
          default: queue_byte(CH_QUOTE);
        endcase
      end
    endcase
  endfunction

  function automatic void build_file();
    int target;
    file_q.delete();
    if ($urandom_range(0, 19) == 0) begin
      queue_byte(8'($urandom_range(0, 255)));
    end else begin
      target = $urandom_range(4, 60);
      while (file_q.size() < target) add_fragment();
    end
  endfunction

  task automatic send_text(input logic [7:0] b, input logic eof);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      text_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    text_valid  <= 1'b1;
    text_byte   <= b;
    end_of_file <= eof;
    @(posedge clk);
    while (text_stall) @(posedge clk);
  endtask

  task automatic send_file(input bit close);
    foreach (file_q[i]) send_text(file_q[i], close && (i == file_q.size() - 1));
  endtask

  // wait until every predicted call has come and the pipeline is empty
  task automatic settle();
    text_valid <= 1'b0;
    @(posedge clk);
    while (calls_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_name(input logic [NAME_LEN_W-1:0] raw_len);
    logic [CFG_W-1:0] lo;
    logic [CFG_W-1:0] hi;
    logic [CFG_W-1:0] junk;
    for (int i = 0; i < 8; i++) begin
      lo[i*8 +: 8] = name_buf[i];
      hi[i*8 +: 8] = name_buf[i+8];
    end
    junk = $urandom_range(0, 1) ? {$urandom, $urandom} : '0;
    write_reg(REG_NAME_LOW, lo);
    write_reg(REG_NAME_HIGH, hi);
    write_reg(REG_NAME_LEN, {junk[CFG_W-1:NAME_LEN_W], raw_len});
  endtask

  task automatic set_name_str(input string s);
    for (int i = 0; i < NAME_SLOTS; i++) name_buf[i] = (i < s.len()) ? s[i] : 8'h00;
    name_n = s.len();
    load_name(NAME_LEN_W'(s.len()));
  endtask

  task automatic pick_random_name();
    int                    kind;
    logic [NAME_LEN_W-1:0] raw;
    case ($urandom_range(0, 9))
      0: raw = NAME_LEN_W'(1);
      1: raw = NAME_LEN_W'(NAME_SLOTS);
      2: raw = '0;
      3: raw = NAME_LEN_W'($urandom_range(NAME_SLOTS + 1, 31));
      default: raw = NAME_LEN_W'($urandom_range(2, 6));
    endcase
    name_n = (raw == 0) ? 1 : (int'(raw) > NAME_SLOTS) ? NAME_SLOTS : int'(raw);
    kind = $urandom_range(0, 9);
    for (int i = 0; i < NAME_SLOTS; i++) begin
      if (i >= name_n) name_buf[i] = 8'($urandom_range(0, 255));
      else if (kind < 6) name_buf[i] = pick_word_char();
      else if (kind < 8) name_buf[i] = pick_symbol();
      else if (kind < 9) name_buf[i] = $urandom_range(0, 1) ? pick_word_char() : pick_symbol();
      else name_buf[i] = 8'($urandom_range(0, 255));
    end
    load_name(raw);
    if ($urandom_range(0, 4) == 0) write_reg(REG_SPARE, {$urandom, $urandom});
  endtask

  initial begin : call_sink
    int gap;
    rx_stall = 1'b0;
    forever begin
      gap = rx_idle_on ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
        rx_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      rx_stall <= 1'b0;
      @(posedge clk);
      while (!(call_valid && !call_stall)) @(posedge clk);
    end
  end

  initial begin : call_hold
    long_hold = 1'b0;
    wait (hold_req);
    @(posedge clk);
    long_hold <= 1'b1;
    repeat (LONG_HOLD_CYCLES) @(posedge clk);
    long_hold <= 1'b0;
  end

  initial begin : stimulus
    int n_files;
    rst          = 1'b1;
    text_valid   = 1'b0;
    text_byte    = '0;
    end_of_file  = 1'b0;
    cfg_write    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    tx_idle_on   = 1'b1;
    rx_idle_on   = 1'b1;
    hold_req     = 1'b0;
    random_bytes = 0;
    phase        = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // calls in code, strings with escapes, line and block comments
    set_name_str("ab");
    file_q.delete();
    push_str("ab (xab(\"a\\\"ab(\"//ab(\nab(/*ab(*/ab\t(");
    send_file(1'b1);
    settle();

    // match starting on a slash, plain and as comment opener
    set_name_str("/");
    file_q.delete();
    push_str("a/ (a//(");
    send_file(1'b1);
    settle();

    // shorter name written in the middle of a match
    set_name_str("abc");
    file_q.delete();
    push_str("ab");
    send_file(1'b0);
    settle();
    write_reg(REG_NAME_LEN, CFG_W'(2));
    file_q.delete();
    push_str("c(");
    send_file(1'b1);
    settle();

    while (random_bytes < RANDOM_BYTES) begin
      pick_random_name();
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      if (phase == 2) begin
        hold_req   = 1'b1;
        tx_idle_on = 1'b0;
      end
      n_files = $urandom_range(1, 4);
      for (int f = 0; f < n_files; f++) begin
        build_file();
        send_file((f < n_files - 1) || ($urandom_range(0, 3) != 0));
        random_bytes += file_q.size();
      end
      settle();
      phase++;
    end

    if (fail_count == 0 && calls_pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
